// ===== hw/rtl/bicu_pkg.sv =====
package bicu_pkg;

   localparam int MAX_WIDTH_DEF = 2048;
   localparam int MAX_SCALE_DEF = 8;

   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_SCALE  = 2'd2;

   typedef logic signed [17:0] weight_type;

   // Q1.16 Catmull-Rom weight m for fraction l/s, s in 1..8, l < s
   function automatic weight_type cr_weight(input logic [3:0] l, input logic [3:0] s,
                                            input logic [1:0] m);
      longint ll, ss, s2, s3, l2, l3, a, n, d, lo, hi, mid;
      begin
         ll = longint'(l);
         ss = longint'(s);
         s2 = ss * ss;
         s3 = s2 * ss;
         l2 = ll * ll;
         l3 = l2 * ll;
         case (m)
            2'd0:    a = -ll * s2 + 2 * l2 * ss - l3;
            2'd1:    a = 2 * s3 - 5 * l2 * ss + 3 * l3;
            2'd2:    a = ll * s2 + 4 * l2 * ss - 3 * l3;
            default: a = -l2 * ss + l3;
         endcase
         n = 65536 * a + s3;
         d = 2 * s3;
         // floor(n / d) by bisection: keep lo*d <= n < hi*d
         lo = -131072;
         hi = 131072;
         for (int b = 0; b < 18; b++) begin
            mid = (lo + hi) >>> 1;
            if (mid * d <= n) lo = mid;
            else hi = mid;
         end
         cr_weight = weight_type'(lo);
      end
   endfunction

   // weight table indexed {s-1, l, m}: s-1 and l in 0..7
   typedef weight_type wtab_type [0:255];

   function automatic wtab_type build_wtab();
      wtab_type t;
      logic [3:0] sv, lv;
      begin
         for (int i = 0; i < 256; i++) begin
            sv = 4'(i[7:5]) + 4'd1;
            lv = 4'(i[4:2]);
            if (lv < sv) t[i] = cr_weight(lv, sv, i[1:0]);
            else t[i] = '0;
         end
         build_wtab = t;
      end
   endfunction

   localparam wtab_type WTAB = build_wtab();

endpackage

// ===== hw/rtl/bicubic_upscaler_core.sv =====
// Each pixel transfer is followed by the three serial line memory reads and the window load,
// then, with a full window, by four row MAC steps and the output load for each result.
// A new pixel is taken only in idle, once the last result of the previous one is loaded;
// row sums and the weighted vertical accumulate run staggered through the MAC steps.
// A stalled result holds the block in its output stage.
// Reset clears counters and control, sets default config; line memory and window hold junk.
module bicubic_upscaler_core #(
   parameter int MAX_WIDTH = bicu_pkg::MAX_WIDTH_DEF,
   parameter int MAX_SCALE = bicu_pkg::MAX_SCALE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_pixel,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_value,
   output logic [18:0] rsp_out_row,
   output logic [13:0] rsp_out_col,
   output logic        rsp_last_of_run,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_write_data
);
   localparam int CW = $clog2(MAX_WIDTH);
   localparam int DEPTH = 3 * MAX_WIDTH;
   localparam int AW = $clog2(DEPTH);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_READ = 5'b00010,
      S_LOAD = 5'b00100,
      S_MAC  = 5'b01000,
      S_OUT  = 5'b10000
   } state_type;

   state_type   state_ff, state_in;
   logic [11:0] width_ff;
   logic [15:0] height_ff;
   logic [3:0]  scale_ff;
   logic [CW-1:0] col_ff, col_in;
   logic [15:0] row_ff, row_in;
   logic [1:0]  slot_ff, slot_in;
   logic [7:0]  pix_ff;
   logic [7:0]  win_ff [0:3][0:3];
   logic [3:0]  k_ff, k_in, l_ff, l_in;
   logic [1:0]  y_ff, y_in;
   logic signed [31:0] hs_ff;
   logic signed [63:0] acc_ff;
   logic [1:0]  rd_ph_ff;
   logic        rsp_valid_ff;
   logic [7:0]  value_ff;
   logic [18:0] orow_ff;
   logic [13:0] ocol_ff;
   logic        last_ff;
   logic [CW-1:0] jc_ff;
   logic [15:0]   ir_ff;

   logic [7:0]  mem [0:DEPTH-1];
   logic [7:0]  rdata_ff;
   logic [7:0]  rd_a_ff, rd_b_ff;

   // effective configuration
   logic [CW:0] w_eff;
   logic [15:0] h_eff;
   logic [3:0]  s_eff;
   always_comb begin
      if (width_ff == 12'd0) w_eff = (CW+1)'(1);
      else if ({4'd0, width_ff} > 16'(MAX_WIDTH)) w_eff = (CW+1)'(MAX_WIDTH);
      else w_eff = (CW+1)'(width_ff);
      h_eff = (height_ff == 16'd0) ? 16'd1 : height_ff;
      if (scale_ff == 4'd0) s_eff = 4'd1;
      else if (scale_ff > 4'(MAX_SCALE)) s_eff = 4'(MAX_SCALE);
      else s_eff = scale_ff;
   end

   logic [1:0] slot_b, slot_c;
   assign slot_b = (slot_ff == 2'd2) ? 2'd0 : slot_ff + 2'd1;
   assign slot_c = (slot_b == 2'd2) ? 2'd0 : slot_b + 2'd1;

   function automatic logic [AW-1:0] addr_of(input logic [1:0] sl, input logic [CW-1:0] c);
      addr_of = AW'(32'(sl) * MAX_WIDTH + 32'(c));
   endfunction

   logic [AW-1:0] rd_addr;
   always_comb begin
      case (rd_ph_ff)
         2'd0:    rd_addr = addr_of(slot_ff, col_ff);
         2'd1:    rd_addr = addr_of(slot_b, col_ff);
         default: rd_addr = addr_of(slot_c, col_ff);
      endcase
   end

   // line memory: read each cycle, write the new pixel when the reads are done
   always_ff @(posedge clock) begin
      rdata_ff <= mem[rd_addr];
      if (state_ff == S_LOAD) mem[addr_of(slot_ff, col_ff)] <= pix_ff;
   end

   // weight lookup; vertical weight belongs to the row whose sum sits in hs_ff
   logic [7:0] wh_idx, wv_idx;
   logic signed [17:0] wh [0:3];
   logic signed [17:0] wv;
   assign wv_idx = {3'(s_eff - 4'd1), k_ff[2:0], y_ff - 2'd1};
   assign wv = bicu_pkg::WTAB[wv_idx];
   always_comb begin
      wh_idx = '0;
      for (int m = 0; m < 4; m++) begin
         wh_idx = {3'(s_eff - 4'd1), l_ff[2:0], 2'(m)};
         wh[m] = bicu_pkg::WTAB[wh_idx];
      end
   end

   // horizontal row sum for row y
   logic signed [31:0] hs_comb;
   always_comb begin
      hs_comb = '0;
      for (int x = 0; x < 4; x++)
         hs_comb = hs_comb + 32'(wh[x] * $signed({1'b0, win_ff[y_ff][x]}));
   end

   logic last_pix_of_run;
   assign last_pix_of_run = (k_ff == s_eff - 4'd1) && (l_ff == s_eff - 4'd1);

   logic signed [63:0] prod;
   assign prod = 64'(wv * hs_ff);

   // final row term lands on entry to output stage
   logic signed [63:0] acc_fin;
   assign acc_fin = acc_ff + prod;

   logic signed [31:0] vq;
   assign vq = acc_fin[63:32];

   logic has_win;
   assign has_win = (row_ff >= 16'd3) && (col_ff >= CW'(3));

   assign req_ready = (state_ff == S_IDLE) && !csr_write_enable;

   always_comb begin
      state_in = state_ff;
      col_in = col_ff;
      row_in = row_ff;
      slot_in = slot_ff;
      k_in = k_ff;
      l_in = l_ff;
      y_in = y_ff;
      case (state_ff)
         S_IDLE: if (req_valid && req_ready) state_in = S_READ;
         S_READ: if (rd_ph_ff == 2'd3) state_in = S_LOAD;
         S_LOAD: begin
            k_in = '0;
            l_in = '0;
            y_in = '0;
            if (has_win) state_in = S_MAC;
            else state_in = S_IDLE;
            // advance counters
            if ({1'b0, col_ff} + (CW+1)'(1) >= w_eff) begin
               col_in = '0;
               slot_in = slot_b;
               if (row_ff + 16'd1 >= h_eff) begin
                  row_in = '0;
                  slot_in = '0;
               end else row_in = row_ff + 16'd1;
            end else col_in = col_ff + CW'(1);
         end
         S_MAC: begin
            // last row term is added on the way into the output stage
            if (y_ff == 2'd3) state_in = S_OUT;
            y_in = y_ff + 2'd1;
         end
         S_OUT: if (!rsp_valid_ff || rsp_ready) begin
            y_in = '0;
            if (last_pix_of_run) state_in = S_IDLE;
            else begin
               state_in = S_MAC;
               if (l_ff == s_eff - 4'd1) begin
                  l_in = '0;
                  k_in = k_ff + 4'd1;
               end else l_in = l_ff + 4'd1;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (csr_write_enable) begin
         col_in = '0;
         row_in = '0;
         slot_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         width_ff <= 12'd2048;
         height_ff <= 16'd4;
         scale_ff <= 4'd2;
         col_ff <= '0;
         row_ff <= '0;
         slot_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rd_ph_ff <= '0;
      end else begin
         state_ff <= state_in;
         col_ff <= col_in;
         row_ff <= row_in;
         slot_ff <= slot_in;
         if (csr_write_enable) begin
            case (csr_index)
               bicu_pkg::CSR_WIDTH:  width_ff <= csr_write_data[11:0];
               bicu_pkg::CSR_HEIGHT: height_ff <= csr_write_data;
               bicu_pkg::CSR_SCALE:  scale_ff <= csr_write_data[3:0];
               default: ;
            endcase
         end
         if (state_ff == S_READ) rd_ph_ff <= rd_ph_ff + 2'd1;
         else rd_ph_ff <= '0;
         if (state_ff == S_OUT && (!rsp_valid_ff || rsp_ready)) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      k_ff <= k_in;
      l_ff <= l_in;
      y_ff <= y_in;
      if (req_valid && req_ready) pix_ff <= req_pixel;
      if (state_ff == S_READ && rd_ph_ff == 2'd1) rd_a_ff <= rdata_ff;
      if (state_ff == S_READ && rd_ph_ff == 2'd2) rd_b_ff <= rdata_ff;
      // shift window when all three line reads are back
      if (state_ff == S_LOAD) begin
         for (int y = 0; y < 4; y++)
            for (int x = 0; x < 3; x++)
               win_ff[y][x] <= win_ff[y][x+1];
         win_ff[0][3] <= rd_a_ff;
         win_ff[1][3] <= rd_b_ff;
         win_ff[2][3] <= rdata_ff;
         win_ff[3][3] <= pix_ff;
         jc_ff <= col_ff - CW'(2);
         ir_ff <= row_ff - 16'd2;
      end
      // row sum registered, then weighted into the vertical accumulate on the next step
      if (state_ff == S_MAC) begin
         hs_ff <= hs_comb;
         if (y_ff == 2'd0) acc_ff <= '0;
         else acc_ff <= acc_ff + prod;
      end
      if (state_ff == S_OUT && (!rsp_valid_ff || rsp_ready)) begin
         if (vq < 0) value_ff <= 8'd0;
         else if (vq > 32'sd255) value_ff <= 8'd255;
         else value_ff <= vq[7:0];
         orow_ff <= 19'(32'(ir_ff) * 32'(s_eff) + 32'(k_ff));
         ocol_ff <= 14'(32'(jc_ff) * 32'(s_eff) + 32'(l_ff));
         last_ff <= last_pix_of_run;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = value_ff;
   assign rsp_out_row = orow_ff;
   assign rsp_out_col = ocol_ff;
   assign rsp_last_of_run = last_ff;
endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

typedef struct {
   logic [7:0]  value;
   logic [18:0] out_row;
   logic [13:0] out_col;
   logic        last_of_run;
} upscaled_px_type;

// Predicts upscaled pixels from the source stream and checks the block output
class upscale_scoreboard_type;
   logic [7:0]  line_mem [0:3*bicu_pkg::MAX_WIDTH_DEF-1];
   logic [7:0]  win [0:3][0:3];
   int unsigned col_cnt, row_cnt;
   int unsigned img_w, img_h, img_scale;
   upscaled_px_type pending[$];
   int unsigned mismatch_count;

   function new();
      img_w = 2048;
      img_h = 4;
      img_scale = 2;
      col_cnt = 0;
      row_cnt = 0;
      mismatch_count = 0;
      foreach (line_mem[i]) line_mem[i] = '0;
      foreach (win[y, x]) win[y][x] = '0;
   endfunction

   function void note_csr(logic [1:0] idx, logic [15:0] data);
      case (idx)
         bicu_pkg::CSR_WIDTH:  img_w = data[11:0];
         bicu_pkg::CSR_HEIGHT: img_h = data;
         bicu_pkg::CSR_SCALE:  img_scale = data[3:0];
         default: return;
      endcase
      col_cnt = 0;
      row_cnt = 0;
   endfunction

   // Q1.16 weight for fraction l/s, computed exactly with half-up rounding
   function longint cr_coef(longint l, longint s, int m);
      longint s2, s3, l2, l3, a, n, q;
      s2 = s * s;
      s3 = s2 * s;
      l2 = l * l;
      l3 = l2 * l;
      case (m)
         0: a = -l * s2 + 2 * l2 * s - l3;
         1: a = 2 * s3 - 5 * l2 * s + 3 * l3;
         2: a = l * s2 + 4 * l2 * s - 3 * l3;
         default: a = -l2 * s + l3;
      endcase
      n = 65536 * a + s3;
      q = n / (2 * s3);
      if ((n % (2 * s3)) != 0 && n < 0) q = q - 1;
      return q;
   endfunction

   // Shift the pixel into line and window stores and queue its upscaled run
   function void note_pixel(logic [7:0] px);
      int unsigned w, h, s, r, c, sa, sb, sc;
      longint wv[4], wh[4], acc, hsum, v;
      upscaled_px_type o;
      w = img_w;
      h = img_h;
      s = img_scale;
      r = row_cnt;
      c = col_cnt;
      if (w < 1) w = 1;
      if (w > bicu_pkg::MAX_WIDTH_DEF) w = bicu_pkg::MAX_WIDTH_DEF;
      if (h < 1) h = 1;
      if (s < 1) s = 1;
      if (s > bicu_pkg::MAX_SCALE_DEF) s = bicu_pkg::MAX_SCALE_DEF;
      if (c >= w) c = 0;
      sa = r % 3;
      sb = (r + 1) % 3;
      sc = (r + 2) % 3;
      for (int y = 0; y < 4; y++)
         for (int x = 0; x < 3; x++) win[y][x] = win[y][x+1];
      win[0][3] = line_mem[sa*bicu_pkg::MAX_WIDTH_DEF + c];
      win[1][3] = line_mem[sb*bicu_pkg::MAX_WIDTH_DEF + c];
      win[2][3] = line_mem[sc*bicu_pkg::MAX_WIDTH_DEF + c];
      win[3][3] = px;
      line_mem[sa*bicu_pkg::MAX_WIDTH_DEF + c] = px;
      if (r >= 3 && c >= 3) begin
         for (int k = 0; k < s; k++) begin
            for (int m = 0; m < 4; m++) wv[m] = cr_coef(k, s, m);
            for (int l = 0; l < s; l++) begin
               for (int m = 0; m < 4; m++) wh[m] = cr_coef(l, s, m);
               acc = 0;
               for (int y = 0; y < 4; y++) begin
                  hsum = 0;
                  for (int x = 0; x < 4; x++) hsum += wh[x] * longint'(win[y][x]);
                  acc += wv[y] * hsum;
               end
               v = acc >>> 32;
               if (v < 0) v = 0;
               if (v > 255) v = 255;
               o.value = v[7:0];
               o.out_row = 19'((r - 2) * s + k);
               o.out_col = 14'((c - 2) * s + l);
               o.last_of_run = (k == s - 1 && l == s - 1);
               pending.push_back(o);
            end
         end
      end
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      col_cnt = c;
      row_cnt = r;
   endfunction

   function void check_pixel(upscaled_px_type got);
      upscaled_px_type want;
      if (pending.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("unexpected output row %0d col %0d value %0d",
                     got.out_row, got.out_col, got.value);
         return;
      end
      want = pending.pop_front();
      if (got.value !== want.value || got.out_row !== want.out_row ||
          got.out_col !== want.out_col || got.last_of_run !== want.last_of_run) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch: expected v=%0d r=%0d c=%0d last=%0d, got v=%0d r=%0d c=%0d last=%0d",
                     want.value, want.out_row, want.out_col, want.last_of_run,
                     got.value, got.out_row, got.out_col, got.last_of_run);
      end
   endfunction
endclass

module tb_top;
   localparam int CYCLE_LIMIT = 10000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_pixel = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_value;
   logic [18:0] rsp_out_row;
   logic [13:0] rsp_out_col;
   logic        rsp_last_of_run;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_write_data = '0;

   upscale_scoreboard_type sb = new();
   int unsigned cycle_count = 0;
   bit          hold_off = 1'b0;
   int          frame_mode = 0;

   bicubic_upscaler_core dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Model updates on input transfers, check on output transfers
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) sb.note_pixel(req_pixel);
      if (!reset && rsp_valid && rsp_ready)
         sb.check_pixel(upscaled_px_type'{rsp_value, rsp_out_row, rsp_out_col,
                                          rsp_last_of_run});
   end

   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 45) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Receiver: random stalls, with a long hold-off when requested
   initial begin
      int g;
      @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_ready <= 1'b0;
            repeat (400) @(negedge clock);
            hold_off = 1'b0;
         end
         g = (frame_mode == 1) ? 0 : gap_len();
         if (g == 0) begin
            rsp_ready <= 1'b1;
            @(negedge clock);
         end else begin
            rsp_ready <= 1'b0;
            repeat (g) @(negedge clock);
         end
      end
   end

   // Offer one pixel; valid drops only ahead of a gap or at the end of a frame
   task automatic send_pixel(logic [7:0] px, bit gaps);
      int g;
      g = gaps ? gap_len() : 0;
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= px;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (300) @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [15:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      sb.note_csr(idx, data);
      @(negedge clock);
   endtask

   task automatic configure(int w, int h, int s);
      write_csr(bicu_pkg::CSR_WIDTH, 16'(w));
      write_csr(bicu_pkg::CSR_HEIGHT, 16'(h));
      write_csr(bicu_pkg::CSR_SCALE, 16'(s));
      csr_write_enable <= 1'b0;
   endtask

   // Stream a full frame; pattern 0 random, 1 extremes, 2 ramp
   task automatic send_frame(int w, int h, int pattern, bit gaps);
      logic [7:0] px;
      for (int n = 0; n < w * h; n++) begin
         case (pattern)
            1: px = ($urandom_range(0, 1)) ? 8'hFF : 8'h00;
            2: px = 8'(n * 37);
            default: px = 8'($urandom);
         endcase
         send_pixel(px, gaps);
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      int w, h, s, total;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: extremes on smallest frame at scale 1 and 8
      configure(4, 4, 1);
      send_frame(4, 4, 1, 1'b0);
      drain();
      configure(4, 4, 8);
      send_frame(4, 4, 1, 1'b1);
      drain();
      // Height of zero acts as one: no output
      configure(5, 0, 3);
      send_frame(5, 1, 2, 1'b1);
      drain();
      // Width below minimum yields no output
      configure(3, 5, 2);
      send_frame(3, 5, 0, 1'b1);
      drain();

      // Long receiver hold-off while the sender keeps going
      configure(6, 5, 4);
      hold_off = 1'b1;
      send_frame(6, 5, 0, 1'b0);
      drain();

      // Random frames; scale 0 and 15 test clamping
      total = 0;
      while (total < 420) begin
         w = $urandom_range(4, 9);
         h = $urandom_range(4, 7);
         case ($urandom_range(0, 5))
            0: s = 0;
            1: s = 15;
            default: s = $urandom_range(1, 8);
         endcase
         if (s == 0 || s > 5) h = 4;
         configure(w, h, s);
         frame_mode = $urandom_range(0, 3) == 0;
         send_frame(w, h, $urandom_range(0, 2), 1'b1);
         total += w * h;
         drain();
      end
      frame_mode = 0;

      if (sb.mismatch_count == 0 && sb.pending.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
